>>> sv/met_pkg.sv
// Shared types, constants and microcode table for the escape-time block.
`timescale 1ns / 1ps

package met_pkg;

  localparam int IDX_W   = 12;
  localparam int CNT_W   = 16;
  localparam int RAD_W   = 3;
  localparam int ORG_W   = 32;
  localparam int STEP_W  = 31;
  localparam int Z_W     = 64;
  localparam int CFG_W   = 32;
  localparam int UPC_W   = 5;

  typedef logic [2:0]       reg_idx_t;
  typedef logic [UPC_W-1:0] upc_t;
  typedef logic [2:0]       arg_t;

  localparam reg_idx_t REG_X_ORIGIN  = 3'd0;
  localparam reg_idx_t REG_Y_ORIGIN  = 3'd1;
  localparam reg_idx_t REG_X_STEP    = 3'd2;
  localparam reg_idx_t REG_Y_STEP    = 3'd3;
  localparam reg_idx_t REG_ITER_LIM  = 3'd4;
  localparam reg_idx_t REG_ESC_RAD   = 3'd5;

  localparam logic signed [ORG_W-1:0] RST_X_ORIGIN = -32'sd536870912;
  localparam logic signed [ORG_W-1:0] RST_Y_ORIGIN = -32'sd332859965;
  localparam logic [STEP_W-1:0]       RST_X_STEP   = 31'd612032;
  localparam logic [STEP_W-1:0]       RST_Y_STEP   = 31'd665720;
  localparam logic [CNT_W-1:0]        RST_ITER_LIM = 16'd100;
  localparam logic [RAD_W-1:0]        RST_ESC_RAD  = 3'd2;

  localparam logic [Z_W-1:0] Z_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [Z_W-1:0] Z_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [ORG_W-1:0] x_origin;
    logic signed [ORG_W-1:0] y_origin;
    logic [STEP_W-1:0]       x_step;
    logic [STEP_W-1:0]       y_step;
    logic [CNT_W-1:0]        iter_limit;
    logic [RAD_W-1:0]        esc_radius;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP  = 4'd0,
    OP_LOAD = 4'd1,
    OP_MUL  = 4'd2,
    OP_FIN  = 4'd3,
    OP_AXIS = 4'd4,
    OP_TEST = 4'd5,
    OP_DIFF = 4'd6,
    OP_UPD  = 4'd7,
    OP_OUT  = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    JC_NEXT     = 2'd0,
    JC_ALWAYS   = 2'd1,
    JC_FINISH   = 2'd2,
    JC_WAIT_OUT = 2'd3
  } jc_e;

  // operand pairs for OP_LOAD
  localparam arg_t LD_XCOL = 3'd0;
  localparam arg_t LD_YROW = 3'd1;
  localparam arg_t LD_XX   = 3'd2;
  localparam arg_t LD_YY   = 3'd3;
  localparam arg_t LD_XY   = 3'd4;
  // partial products for OP_MUL: bit 1 = high half of a, bit 0 = high half of b
  localparam arg_t PP_LL   = 3'd0;
  localparam arg_t PP_LH   = 3'd1;
  localparam arg_t PP_HL   = 3'd2;
  localparam arg_t PP_HH   = 3'd3;
  // destinations for OP_FIN
  localparam arg_t FD_XX   = 3'd0;
  localparam arg_t FD_YY   = 3'd1;
  localparam arg_t FD_XY   = 3'd2;
  // axis for OP_AXIS
  localparam arg_t AX_X    = 3'd0;
  localparam arg_t AX_Y    = 3'd1;
  localparam arg_t ARG_NONE = 3'd0;

  localparam upc_t UPC_LOOP = 5'd6;
  localparam upc_t UPC_DONE = 5'd27;

  typedef struct packed {
    op_e  op;
    arg_t arg;
  } ctrl_t;

  typedef struct packed {
    logic finish;
    logic out_free;
  } stat_t;

  typedef struct packed {
    op_e  op;
    arg_t arg;
    jc_e  jc;
    upc_t target;
  } uword_t;

  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      5'd0:  w = '{OP_LOAD, LD_XCOL,  JC_NEXT,     '0};
      5'd1:  w = '{OP_MUL,  PP_LL,    JC_NEXT,     '0};
      5'd2:  w = '{OP_AXIS, AX_X,     JC_NEXT,     '0};
      5'd3:  w = '{OP_LOAD, LD_YROW,  JC_NEXT,     '0};
      5'd4:  w = '{OP_MUL,  PP_LL,    JC_NEXT,     '0};
      5'd5:  w = '{OP_AXIS, AX_Y,     JC_NEXT,     '0};
      5'd6:  w = '{OP_LOAD, LD_XX,    JC_NEXT,     '0};
      5'd7:  w = '{OP_MUL,  PP_LL,    JC_NEXT,     '0};
      5'd8:  w = '{OP_MUL,  PP_LH,    JC_NEXT,     '0};
      5'd9:  w = '{OP_MUL,  PP_HL,    JC_NEXT,     '0};
      5'd10: w = '{OP_MUL,  PP_HH,    JC_NEXT,     '0};
      5'd11: w = '{OP_FIN,  FD_XX,    JC_NEXT,     '0};
      5'd12: w = '{OP_LOAD, LD_YY,    JC_NEXT,     '0};
      5'd13: w = '{OP_MUL,  PP_LL,    JC_NEXT,     '0};
      5'd14: w = '{OP_MUL,  PP_LH,    JC_NEXT,     '0};
      5'd15: w = '{OP_MUL,  PP_HL,    JC_NEXT,     '0};
      5'd16: w = '{OP_MUL,  PP_HH,    JC_NEXT,     '0};
      5'd17: w = '{OP_FIN,  FD_YY,    JC_NEXT,     '0};
      5'd18: w = '{OP_TEST, ARG_NONE, JC_FINISH,   UPC_DONE};
      5'd19: w = '{OP_LOAD, LD_XY,    JC_NEXT,     '0};
      5'd20: w = '{OP_MUL,  PP_LL,    JC_NEXT,     '0};
      5'd21: w = '{OP_MUL,  PP_LH,    JC_NEXT,     '0};
      5'd22: w = '{OP_MUL,  PP_HL,    JC_NEXT,     '0};
      5'd23: w = '{OP_MUL,  PP_HH,    JC_NEXT,     '0};
      5'd24: w = '{OP_FIN,  FD_XY,    JC_NEXT,     '0};
      5'd25: w = '{OP_DIFF, ARG_NONE, JC_NEXT,     '0};
      5'd26: w = '{OP_UPD,  ARG_NONE, JC_ALWAYS,   UPC_LOOP};
      5'd27: w = '{OP_OUT,  ARG_NONE, JC_WAIT_OUT, '0};
      default: w = '{OP_NOP, ARG_NONE, JC_WAIT_OUT, '0};
    endcase
    return w;
  endfunction

endpackage

>>> sv/met_pix_if.sv
// Pixel input channel: valid/ready with column and row.
`timescale 1ns / 1ps

interface met_pix_if;
  logic                     valid;
  logic                     ready;
  logic [met_pkg::IDX_W-1:0] pixel_column;
  logic [met_pkg::IDX_W-1:0] pixel_row;

  modport source (output valid, pixel_column, pixel_row, input ready);
  modport sink   (input valid, pixel_column, pixel_row, output ready);
endinterface

>>> sv/met_res_if.sv
// Result channel: valid/ready with count, inside flag and final z.
`timescale 1ns / 1ps

interface met_res_if;
  logic                            valid;
  logic                            ready;
  logic [met_pkg::CNT_W-1:0]        iteration_count;
  logic                            inside_set;
  logic signed [met_pkg::Z_W-1:0]   final_real;
  logic signed [met_pkg::Z_W-1:0]   final_imag;

  modport source (output valid, iteration_count, inside_set, final_real, final_imag,
                  input ready);
  modport sink   (input valid, iteration_count, inside_set, final_real, final_imag,
                  output ready);
endinterface

>>> sv/met_sequencer.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps

module met_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  met_pkg::stat_t stat_i,
  output met_pkg::ctrl_t ctrl_o,
  output logic           busy_o
);

  logic            busy_q, busy_d;
  met_pkg::upc_t   upc_q, upc_d;
  met_pkg::uword_t uw;

  assign uw = met_pkg::ucode(upc_q);

  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (start_i) begin
      busy_d = 1'b1;
      upc_d  = '0;
    end else if (busy_q) begin
      unique case (uw.jc)
        met_pkg::JC_NEXT:     upc_d = upc_q + 1'b1;
        met_pkg::JC_ALWAYS:   upc_d = uw.target;
        met_pkg::JC_FINISH:   upc_d = stat_i.finish ? uw.target : upc_q + 1'b1;
        met_pkg::JC_WAIT_OUT: begin
          if (stat_i.out_free) busy_d = 1'b0;
        end
        default: upc_d = upc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

  assign ctrl_o.op  = busy_q ? uw.op : met_pkg::OP_NOP;
  assign ctrl_o.arg = uw.arg;
  assign busy_o     = busy_q;

endmodule

>>> sv/met_datapath.sv
// Datapath: shared 32x32 multiplier, 128-bit accumulator, fixed-point z registers.
`timescale 1ns / 1ps

module met_datapath #(
  parameter int MAX_SIDE         = 4096,
  parameter int EXTRA_ITERATIONS = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  met_pkg::cfg_t                   cfg_i,
  input  logic                            start_i,
  input  logic [met_pkg::IDX_W-1:0]       col_i,
  input  logic [met_pkg::IDX_W-1:0]       row_i,
  input  met_pkg::ctrl_t                  ctrl_i,
  input  logic                            out_ready_i,
  output met_pkg::stat_t                  stat_o,
  output logic                            out_valid_o,
  output logic [met_pkg::CNT_W-1:0]       count_o,
  output logic                            inside_o,
  output logic signed [met_pkg::Z_W-1:0]  real_o,
  output logic signed [met_pkg::Z_W-1:0]  imag_o
);

  localparam int KW = (EXTRA_ITERATIONS > 0) ? $clog2(EXTRA_ITERATIONS + 1) : 1;
  localparam int SW = 17;

  function automatic logic [met_pkg::IDX_W-1:0] clamp_idx(logic [met_pkg::IDX_W-1:0] v);
    if ({5'd0, v} >= SW'(MAX_SIDE)) clamp_idx = met_pkg::IDX_W'(MAX_SIDE - 1);
    else                            clamp_idx = v;
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] v);
    mag64 = v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sadd = s[64] ? met_pkg::Z_MIN : met_pkg::Z_MAX;
    else                sadd = s[63:0];
  endfunction

  logic [met_pkg::IDX_W-1:0] col_q, row_q;
  logic signed [31:0]        cx_q, cy_q;
  logic [63:0]               x_q, y_q, xx_q, yy_q, xy_q;
  logic [63:0]               ma_q, mb_q;
  logic                      neg_q;
  logic [127:0]              acc_q;
  logic [met_pkg::CNT_W-1:0] n_q;
  logic [KW-1:0]             k_q;
  logic                      extra_q;

  logic                      out_valid_q;
  logic [met_pkg::CNT_W-1:0] count_q;
  logic                      inside_q;
  logic [63:0]               real_q, imag_q;

  logic [63:0]  src_a, src_b;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] addend, acc_sum;
  logic         sh31, ovf, frac;
  logic [63:0]  q, fin;
  logic signed [31:0] orig;
  logic [44:0]  axis_sum;
  logic         ax_over, ax_under;
  logic [31:0]  axis_sat;
  logic [63:0]  cx64, cy64, mag2, bound;
  logic [5:0]   rr;
  logic         stop, kdone, out_free;

  always_comb begin
    src_a = x_q;
    src_b = y_q;
    case (ctrl_i.arg)
      met_pkg::LD_XCOL: begin
        src_a = {33'd0, cfg_i.x_step};
        src_b = {52'd0, col_q};
      end
      met_pkg::LD_YROW: begin
        src_a = {33'd0, cfg_i.y_step};
        src_b = {52'd0, row_q};
      end
      met_pkg::LD_XX: begin
        src_a = x_q;
        src_b = x_q;
      end
      met_pkg::LD_YY: begin
        src_a = y_q;
        src_b = y_q;
      end
      default: begin
        src_a = x_q;
        src_b = y_q;
      end
    endcase
  end

  assign a_half = ctrl_i.arg[1] ? ma_q[63:32] : ma_q[31:0];
  assign b_half = ctrl_i.arg[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp     = {32'd0, a_half} * {32'd0, b_half};

  always_comb begin
    case (ctrl_i.arg)
      met_pkg::PP_LL: addend = {64'd0, pp};
      met_pkg::PP_HH: addend = {pp, 64'd0};
      default:        addend = {32'd0, pp, 32'd0};
    endcase
  end
  assign acc_sum = acc_q + addend;

  // floor to Q32.32 with saturation; negation folds the floor correction
  assign sh31 = (ctrl_i.arg == met_pkg::FD_XY);
  assign ovf  = sh31 ? |acc_q[127:95] : |acc_q[127:96];
  assign q    = sh31 ? acc_q[94:31]   : acc_q[95:32];
  assign frac = sh31 ? |acc_q[30:0]   : |acc_q[31:0];

  always_comb begin
    if (!neg_q)            fin = (ovf || q[63]) ? met_pkg::Z_MAX : q;
    else if (ovf || q[63]) fin = met_pkg::Z_MIN;
    else                   fin = frac ? ~q : (~q + 64'd1);
  end

  assign orig     = (ctrl_i.arg == met_pkg::AX_Y) ? cfg_i.y_origin : cfg_i.x_origin;
  assign axis_sum = {{13{orig[31]}}, orig} + {2'b00, acc_q[42:0]};
  assign ax_over  = !axis_sum[44] && (axis_sum[43:31] != 13'h0000);
  assign ax_under = axis_sum[44] && (axis_sum[43:31] != 13'h1FFF);
  assign axis_sat = ax_over ? 32'h7FFF_FFFF : (ax_under ? 32'h8000_0000 : axis_sum[31:0]);

  assign cx64 = {{28{cx_q[31]}}, cx_q, 4'd0};
  assign cy64 = {{28{cy_q[31]}}, cy_q, 4'd0};

  assign mag2  = xx_q + yy_q;
  assign rr    = {3'd0, cfg_i.esc_radius} * {3'd0, cfg_i.esc_radius};
  assign bound = {26'd0, rr, 32'd0};
  assign stop  = !extra_q && ((n_q >= cfg_i.iter_limit) || (mag2 >= bound));
  assign kdone = (k_q == KW'(EXTRA_ITERATIONS));

  assign out_free        = !out_valid_q || out_ready_i;
  assign stat_o.finish   = (extra_q || stop) && kdone;
  assign stat_o.out_free = out_free;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      col_q   <= clamp_idx(col_i);
      row_q   <= clamp_idx(row_i);
      x_q     <= '0;
      y_q     <= '0;
      n_q     <= '0;
      k_q     <= '0;
      extra_q <= 1'b0;
    end else begin
      unique case (ctrl_i.op)
        met_pkg::OP_LOAD: begin
          ma_q  <= mag64(src_a);
          mb_q  <= mag64(src_b);
          neg_q <= src_a[63] ^ src_b[63];
          acc_q <= '0;
        end
        met_pkg::OP_MUL: acc_q <= acc_sum;
        met_pkg::OP_FIN: begin
          case (ctrl_i.arg)
            met_pkg::FD_XX: xx_q <= fin;
            met_pkg::FD_YY: yy_q <= fin;
            default:        xy_q <= fin;
          endcase
        end
        met_pkg::OP_AXIS: begin
          if (ctrl_i.arg == met_pkg::AX_Y) cy_q <= axis_sat;
          else                             cx_q <= axis_sat;
        end
        met_pkg::OP_TEST: extra_q <= extra_q | stop;
        met_pkg::OP_DIFF: xx_q <= xx_q - yy_q;
        met_pkg::OP_UPD: begin
          x_q <= sadd(xx_q, cx64);
          y_q <= sadd(xy_q, cy64);
          if (extra_q) k_q <= k_q + 1'b1;
          else         n_q <= n_q + 1'b1;
        end
        met_pkg::OP_OUT: begin
          if (out_free) begin
            count_q  <= n_q;
            inside_q <= (n_q == cfg_i.iter_limit);
            real_q   <= x_q;
            imag_q   <= y_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.op == met_pkg::OP_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;
  assign inside_o    = inside_q;
  assign real_o      = real_q;
  assign imag_o      = imag_q;

endmodule

>>> sv/mandelbrot_escape_time.sv
// Top level of the Mandelbrot escape-time engine.
// Usage:
//   pix_i carries one pixel item (column, row); it is taken when valid and ready
//   are high. res_o returns one result item per pixel: iteration count, inside
//   flag and the final z in Q32.32. Registers are written through cfg_we_i,
//   cfg_idx_i and cfg_data_i while no item is in flight.
// Timing:
//   One item at a time. After acceptance the item runs n + E iterations, with n
//   the iteration count and E = EXTRA_ITERATIONS. Each iteration is 21 microcode
//   steps, set by one 32x32 multiplier producing three 64x64 squares/products,
//   each from four partial products in turn. The result is in res_o on the cycle
//   after its last step.
// Reset:
//   Registers return to their defaults, no item is held and res_o.valid is low.
// Stall:
//   The result register holds until taken; a new pixel is accepted meanwhile,
//   and its result waits at the last step until the register is free.
`timescale 1ns / 1ps

module mandelbrot_escape_time #(
  parameter int MAX_SIDE         = 4096,
  parameter int EXTRA_ITERATIONS = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  met_pkg::reg_idx_t         cfg_idx_i,
  input  logic [met_pkg::CFG_W-1:0] cfg_data_i,
  met_pix_if.sink                   pix_i,
  met_res_if.source                 res_o
);

  met_pkg::cfg_t  cfg_q;
  met_pkg::ctrl_t ctrl;
  met_pkg::stat_t stat;
  logic           busy;
  logic           accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin   <= met_pkg::RST_X_ORIGIN;
      cfg_q.y_origin   <= met_pkg::RST_Y_ORIGIN;
      cfg_q.x_step     <= met_pkg::RST_X_STEP;
      cfg_q.y_step     <= met_pkg::RST_Y_STEP;
      cfg_q.iter_limit <= met_pkg::RST_ITER_LIM;
      cfg_q.esc_radius <= met_pkg::RST_ESC_RAD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        met_pkg::REG_X_ORIGIN: cfg_q.x_origin   <= cfg_data_i;
        met_pkg::REG_Y_ORIGIN: cfg_q.y_origin   <= cfg_data_i;
        met_pkg::REG_X_STEP:   cfg_q.x_step     <= cfg_data_i[met_pkg::STEP_W-1:0];
        met_pkg::REG_Y_STEP:   cfg_q.y_step     <= cfg_data_i[met_pkg::STEP_W-1:0];
        met_pkg::REG_ITER_LIM: cfg_q.iter_limit <= cfg_data_i[met_pkg::CNT_W-1:0];
        met_pkg::REG_ESC_RAD:  cfg_q.esc_radius <= cfg_data_i[met_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix_i.ready = !busy;
  assign accept      = pix_i.valid && !busy;

  met_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  met_datapath #(
    .MAX_SIDE         (MAX_SIDE),
    .EXTRA_ITERATIONS (EXTRA_ITERATIONS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (accept),
    .col_i       (pix_i.pixel_column),
    .row_i       (pix_i.pixel_row),
    .ctrl_i      (ctrl),
    .out_ready_i (res_o.ready),
    .stat_o      (stat),
    .out_valid_o (res_o.valid),
    .count_o     (res_o.iteration_count),
    .inside_o    (res_o.inside_set),
    .real_o      (res_o.final_real),
    .imag_o      (res_o.final_imag)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> !pix_i.ready)
    else $error("pixel accepted while engine stays ready");

  a_ops_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op != met_pkg::OP_NOP) |-> !pix_i.ready)
    else $error("datapath operation issued while idle");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == met_pkg::OP_OUT && stat.out_free) |=> (res_o.valid && pix_i.ready))
    else $error("result load did not raise valid and release the engine");

endmodule
